// File: sv/tsa_pkg.sv
// ---------------------------------------------------------------------------
// tsa_pkg
// Shared types, codes and the microcode program of the tile slot allocator.
// ---------------------------------------------------------------------------
package tsa_pkg;

    localparam int TILE_W   = 10;
    localparam int SLOT_W   = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;
    localparam int UPC_W    = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    localparam logic [STATUS_W-1:0] ST_NEW     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_READ_HIT,
        OP_ACQ_HIT,
        OP_ACQ_NEW,
        OP_ACQ_FULL,
        OP_IGNORE,
        OP_REL_FREE,
        OP_REL_DEC
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_INPUT,
        HOLD_OUT_BUSY
    } hold_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH
    } jump_t;

    typedef enum logic [2:0] {
        KIND_ACQ_IGNORE,
        KIND_ACQ_HIT,
        KIND_ACQ_FULL,
        KIND_ACQ_NEW,
        KIND_REL_IGNORE,
        KIND_REL_FREE,
        KIND_REL_DEC
    } kind_t;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        jump_t jump;
        upc_t  target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        kind_t kind;
        logic  out_busy;
        logic  init_busy;
    } flags_t;

    localparam upc_t STEP_FETCH     = 4'd0;
    localparam upc_t STEP_DISPATCH  = 4'd1;
    localparam upc_t STEP_HIT_WRITE = 4'd2;
    localparam upc_t DISPATCH_BASE  = 4'd8;
    localparam upc_t STEP_ACQ_IGN   = 4'd8;
    localparam upc_t STEP_HIT_READ  = 4'd9;
    localparam upc_t STEP_ACQ_FULL  = 4'd10;
    localparam upc_t STEP_ACQ_NEW   = 4'd11;
    localparam upc_t STEP_REL_IGN   = 4'd12;
    localparam upc_t STEP_REL_FREE  = 4'd13;
    localparam upc_t STEP_REL_DEC   = 4'd14;

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t uc;
        unique case (addr)
            STEP_FETCH:     uc = '{OP_FETCH,    HOLD_NO_INPUT, JMP_NEXT,     STEP_FETCH};
            STEP_DISPATCH:  uc = '{OP_NOP,      HOLD_NONE,     JMP_DISPATCH, DISPATCH_BASE};
            STEP_HIT_WRITE: uc = '{OP_ACQ_HIT,  HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            STEP_ACQ_IGN:   uc = '{OP_IGNORE,   HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            STEP_HIT_READ:  uc = '{OP_READ_HIT, HOLD_NONE,     JMP_GOTO,     STEP_HIT_WRITE};
            STEP_ACQ_FULL:  uc = '{OP_ACQ_FULL, HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            STEP_ACQ_NEW:   uc = '{OP_ACQ_NEW,  HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            STEP_REL_IGN:   uc = '{OP_IGNORE,   HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            STEP_REL_FREE:  uc = '{OP_REL_FREE, HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            STEP_REL_DEC:   uc = '{OP_REL_DEC,  HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
            default:        uc = '{OP_IGNORE,   HOLD_OUT_BUSY, JMP_GOTO,     STEP_FETCH};
        endcase
        return uc;
    endfunction

endpackage

// File: sv/tsa_ram.sv
// ---------------------------------------------------------------------------
// tsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tsa_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tsa_sequencer.sv
// ---------------------------------------------------------------------------
// tsa_sequencer
// Step counter over the microcode table, with hold and dispatch jumps.
// ---------------------------------------------------------------------------
module tsa_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  tsa_pkg::flags_t flags,
    output tsa_pkg::ctrl_t  ctrl
);

    tsa_pkg::upc_t   upc_reg;
    tsa_pkg::upc_t   upc_next;
    tsa_pkg::ucode_t uc;
    logic            held;

    always_comb
    begin
        uc = tsa_pkg::ucode_rom(upc_reg);
        unique case (uc.hold)
            tsa_pkg::HOLD_NO_INPUT: held = !req_valid;
            tsa_pkg::HOLD_OUT_BUSY: held = flags.out_busy;
            default:                held = 1'b0;
        endcase
        held = held || flags.init_busy;

        if (held)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            unique case (uc.jump)
                tsa_pkg::JMP_GOTO:
                    upc_next = uc.target;
                tsa_pkg::JMP_DISPATCH:
                    upc_next = uc.target + tsa_pkg::UPC_W'(flags.kind);
                default:
                    upc_next = upc_reg + tsa_pkg::UPC_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= tsa_pkg::STEP_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.op   = uc.op;
    assign ctrl.fire = !held;

endmodule

// File: sv/tsa_datapath.sv
// ---------------------------------------------------------------------------
// tsa_datapath
// Maps, count/link store, free-list head, clearing pass and result register.
// ---------------------------------------------------------------------------
module tsa_datapath #(
    parameter int TILE_IDS = 1024,
    parameter int SLOTS    = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsa_pkg::ctrl_t                  ctrl,
    output tsa_pkg::flags_t                 flags,
    output logic                            req_stall,
    input  logic                            req_type,
    input  logic [tsa_pkg::TILE_W-1:0]      tile_id,
    input  logic [tsa_pkg::SLOT_W-1:0]      slot_id,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [tsa_pkg::SLOT_W-1:0]      slot,
    output logic [tsa_pkg::STATUS_W-1:0]    status,
    output logic                            upload_needed
);

    localparam int TW         = $clog2(TILE_IDS);
    localparam int SW         = $clog2(SLOTS);
    localparam int INIT_DEPTH = (TILE_IDS > SLOTS) ? TILE_IDS : SLOTS;
    localparam int IW         = $clog2(INIT_DEPTH);

    // captured word
    logic                         req_reg;
    logic [tsa_pkg::TILE_W-1:0]   tile_reg;
    logic [tsa_pkg::SLOT_W-1:0]   sid_reg;

    logic [SW-1:0]                head_reg;
    logic [SW-1:0]                head_next;
    logic                         init_busy_reg;
    logic [IW-1:0]                init_idx_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [tsa_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [tsa_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_upload_reg;
    logic                         res_load;
    logic [tsa_pkg::SLOT_W-1:0]   res_slot;
    logic [tsa_pkg::STATUS_W-1:0] res_status;
    logic                         res_upload;

    // memory ports
    logic                         t2s_we;
    logic [TW-1:0]                t2s_waddr;
    logic [SW:0]                  t2s_wdata;
    logic                         t2s_re;
    logic [TW-1:0]                t2s_raddr;
    logic [SW:0]                  t2s_rdata;

    logic                         s2t_we;
    logic [SW-1:0]                s2t_waddr;
    logic [TW:0]                  s2t_wdata;
    logic                         s2t_re;
    logic [SW-1:0]                s2t_raddr;
    logic [TW:0]                  s2t_rdata;

    logic                         col_we;
    logic [SW-1:0]                col_waddr;
    logic [tsa_pkg::COUNT_W-1:0]  col_wdata;
    logic                         col_re;
    logic [SW-1:0]                col_raddr;
    logic [tsa_pkg::COUNT_W-1:0]  col_rdata;

    logic [SW-1:0]                hit_slot;
    logic [SW-1:0]                rel_slot;
    logic                         init_in_tiles;
    logic                         init_in_slots;
    logic                         init_last;
    logic                         tile_bad;
    logic                         sid_bad;
    logic                         link_ok;
    tsa_pkg::kind_t               kind;

    tsa_ram #(.DEPTH(TILE_IDS), .WIDTH(SW + 1)) u_t2s (
        .clk   (clk),
        .we    (t2s_we),
        .waddr (t2s_waddr),
        .wdata (t2s_wdata),
        .re    (t2s_re),
        .raddr (t2s_raddr),
        .rdata (t2s_rdata)
    );

    tsa_ram #(.DEPTH(SLOTS), .WIDTH(TW + 1)) u_s2t (
        .clk   (clk),
        .we    (s2t_we),
        .waddr (s2t_waddr),
        .wdata (s2t_wdata),
        .re    (s2t_re),
        .raddr (s2t_raddr),
        .rdata (s2t_rdata)
    );

    tsa_ram #(.DEPTH(SLOTS), .WIDTH(tsa_pkg::COUNT_W)) u_col (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .re    (col_re),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    assign hit_slot      = t2s_rdata[SW-1:0];
    assign rel_slot      = SW'(sid_reg);
    assign init_in_tiles = 32'(init_idx_reg) < 32'(TILE_IDS);
    assign init_in_slots = 32'(init_idx_reg) < 32'(SLOTS);
    assign init_last     = init_idx_reg == IW'(INIT_DEPTH - 1);
    assign tile_bad      = (tile_reg == '0) || (32'(tile_reg) >= 32'(TILE_IDS));
    assign sid_bad       = (sid_reg == '0) || (32'(sid_reg) >= 32'(SLOTS));
    assign link_ok       = 32'(col_rdata) < 32'(SLOTS);

    // classify the captured word
    always_comb
    begin
        if (!req_reg)
        begin
            if (tile_bad)
            begin
                kind = tsa_pkg::KIND_ACQ_IGNORE;
            end
            else if (t2s_rdata[SW])
            begin
                kind = tsa_pkg::KIND_ACQ_HIT;
            end
            else if (head_reg == '0 || 32'(head_reg) >= 32'(SLOTS))
            begin
                kind = tsa_pkg::KIND_ACQ_FULL;
            end
            else
            begin
                kind = tsa_pkg::KIND_ACQ_NEW;
            end
        end
        else
        begin
            if (sid_bad || !s2t_rdata[TW])
            begin
                kind = tsa_pkg::KIND_REL_IGNORE;
            end
            else if (col_rdata <= tsa_pkg::COUNT_ONE)
            begin
                kind = tsa_pkg::KIND_REL_FREE;
            end
            else
            begin
                kind = tsa_pkg::KIND_REL_DEC;
            end
        end
    end

    assign flags.kind      = kind;
    assign flags.out_busy  = out_valid_reg && rsp_stall;
    assign flags.init_busy = init_busy_reg;
    assign req_stall       = init_busy_reg || (ctrl.op != tsa_pkg::OP_FETCH);

    always_comb
    begin
        t2s_we     = 1'b0;
        t2s_waddr  = TW'(tile_reg);
        t2s_wdata  = '0;
        t2s_re     = 1'b0;
        t2s_raddr  = TW'(tile_id);
        s2t_we     = 1'b0;
        s2t_waddr  = rel_slot;
        s2t_wdata  = '0;
        s2t_re     = 1'b0;
        s2t_raddr  = SW'(slot_id);
        col_we     = 1'b0;
        col_waddr  = rel_slot;
        col_wdata  = '0;
        col_re     = 1'b0;
        col_raddr  = req_type ? SW'(slot_id) : head_reg;
        head_next  = head_reg;
        res_load   = 1'b0;
        res_slot   = '0;
        res_status = tsa_pkg::ST_IGNORED;
        res_upload = 1'b0;

        if (init_busy_reg)
        begin
            t2s_we    = init_in_tiles;
            t2s_waddr = TW'(init_idx_reg);
            s2t_we    = init_in_slots;
            s2t_waddr = SW'(init_idx_reg);
            col_we    = init_in_slots;
            col_waddr = SW'(init_idx_reg);
            col_wdata = (32'(init_idx_reg) == SLOTS - 1) ? '0
                        : tsa_pkg::COUNT_W'(32'(init_idx_reg) + 32'd1);
        end
        else if (ctrl.fire)
        begin
            unique case (ctrl.op)
                tsa_pkg::OP_FETCH:
                begin
                    t2s_re = 1'b1;
                    s2t_re = 1'b1;
                    col_re = 1'b1;
                end
                tsa_pkg::OP_READ_HIT:
                begin
                    col_re    = 1'b1;
                    col_raddr = hit_slot;
                end
                tsa_pkg::OP_ACQ_HIT:
                begin
                    col_we     = 1'b1;
                    col_waddr  = hit_slot;
                    col_wdata  = (col_rdata == tsa_pkg::COUNT_MAX) ? col_rdata
                                 : col_rdata + tsa_pkg::COUNT_ONE;
                    res_load   = 1'b1;
                    res_slot   = tsa_pkg::SLOT_W'(hit_slot);
                    res_status = tsa_pkg::ST_HIT;
                end
                tsa_pkg::OP_ACQ_NEW:
                begin
                    t2s_we     = 1'b1;
                    t2s_wdata  = {1'b1, head_reg};
                    s2t_we     = 1'b1;
                    s2t_waddr  = head_reg;
                    s2t_wdata  = {1'b1, TW'(tile_reg)};
                    col_we     = 1'b1;
                    col_waddr  = head_reg;
                    col_wdata  = tsa_pkg::COUNT_ONE;
                    head_next  = link_ok ? col_rdata[SW-1:0] : '0;
                    res_load   = 1'b1;
                    res_slot   = tsa_pkg::SLOT_W'(head_reg);
                    res_status = tsa_pkg::ST_NEW;
                    res_upload = 1'b1;
                end
                tsa_pkg::OP_ACQ_FULL:
                begin
                    res_load   = 1'b1;
                    res_status = tsa_pkg::ST_FULL;
                end
                tsa_pkg::OP_IGNORE:
                begin
                    res_load   = 1'b1;
                    res_status = tsa_pkg::ST_IGNORED;
                end
                tsa_pkg::OP_REL_FREE:
                begin
                    col_we     = 1'b1;
                    col_wdata  = tsa_pkg::COUNT_W'(head_reg);
                    head_next  = rel_slot;
                    t2s_we     = 1'b1;
                    t2s_waddr  = s2t_rdata[TW-1:0];
                    s2t_we     = 1'b1;
                    res_load   = 1'b1;
                    res_status = tsa_pkg::ST_NEW;
                end
                tsa_pkg::OP_REL_DEC:
                begin
                    col_we     = 1'b1;
                    col_wdata  = col_rdata - tsa_pkg::COUNT_ONE;
                    res_load   = 1'b1;
                    res_status = tsa_pkg::ST_HIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid_next = res_load || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= SW'(1);
            init_busy_reg <= 1'b1;
            init_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            if (init_busy_reg)
            begin
                init_idx_reg <= init_idx_reg + IW'(1);
                if (init_last)
                begin
                    init_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire && ctrl.op == tsa_pkg::OP_FETCH && !init_busy_reg)
        begin
            req_reg  <= req_type;
            tile_reg <= tile_id;
            sid_reg  <= slot_id;
        end
        if (res_load)
        begin
            out_slot_reg   <= res_slot;
            out_status_reg <= res_status;
            out_upload_reg <= res_upload;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign slot          = out_slot_reg;
    assign status        = out_status_reg;
    assign upload_needed = out_upload_reg;

endmodule

// File: sv/refcounted_tile_slot_allocator.sv
// ---------------------------------------------------------------------------
// refcounted_tile_slot_allocator
// Reference-counted tile to slot allocator with a free list, run by microcode.
// ---------------------------------------------------------------------------
//  channel | signals                                | direction
//  --------+----------------------------------------+-----------
//  req     | req_valid, req_stall, req_type,        | in
//          | tile_id, slot_id                       |
//  rsp     | rsp_valid, rsp_stall, slot, status,    | out
//          | upload_needed                          |
//
//  Each word runs through fetch (with map reads), dispatch and execute steps;
//  an acquire hit adds a count read step, which needs the tile map read. A
//  clearing pass over max(TILE_IDS, SLOTS) entries follows reset; req_stall
//  stays high through it. The result register holds a stalled rsp word; the
//  next req word is taken meanwhile, and its execute step waits for the slot.
// ---------------------------------------------------------------------------
module refcounted_tile_slot_allocator #(
    parameter int TILE_IDS = 1024,
    parameter int SLOTS    = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         req_type,
    input  logic [tsa_pkg::TILE_W-1:0]   tile_id,
    input  logic [tsa_pkg::SLOT_W-1:0]   slot_id,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [tsa_pkg::SLOT_W-1:0]   slot,
    output logic [tsa_pkg::STATUS_W-1:0] status,
    output logic                         upload_needed
);

    tsa_pkg::ctrl_t  ctrl;
    tsa_pkg::flags_t flags;

    tsa_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    tsa_datapath #(.TILE_IDS(TILE_IDS), .SLOTS(SLOTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .flags         (flags),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .tile_id       (tile_id),
        .slot_id       (slot_id),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .slot          (slot),
        .status        (status),
        .upload_needed (upload_needed)
    );

    a_init_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        flags.init_busy |-> req_stall)
        else $error("word accepted during clearing pass");

    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second word accepted while one is in flight");

    a_upload_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && upload_needed) |-> (slot != '0 && status == tsa_pkg::ST_NEW))
        else $error("upload flagged without a fresh slot");

    a_reject_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == tsa_pkg::ST_IGNORED || status == tsa_pkg::ST_FULL))
        |-> (slot == '0 && !upload_needed))
        else $error("rejected word carries a slot");

endmodule

// File: bench/tb_refcounted_tile_slot_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_refcounted_tile_slot_allocator
// Drives acquire and release words into the tile slot allocator and checks
// every result word against the table's expected word where one is given, else
// a cycle-free model of the tile map, the slot map, the reference counts and the
// free list. A short table of directed words comes first, then random mixes
// around a fill to out-of-space, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module tb_refcounted_tile_slot_allocator;

    localparam int TILE_IDS     = 1024;
    localparam int SLOTS        = 512;
    localparam int MIX_WORDS    = 150;
    localparam int FULL_TRIES   = 6;
    localparam int PRESSURE_AT  = 300;
    localparam int PRESSURE_LEN = 400;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic                       typ;
        logic [tsa_pkg::TILE_W-1:0] tile;
        logic [tsa_pkg::SLOT_W-1:0] sid;
    } word_t;

    typedef struct packed {
        logic [tsa_pkg::SLOT_W-1:0]   slot;
        logic [tsa_pkg::STATUS_W-1:0] status;
        logic                         upload;
    } rsp_t;

    typedef enum logic [2:0] {
        PH_TABLE,
        PH_MIX_A,
        PH_FILL,
        PH_MIX_B,
        PH_DONE
    } phase_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_stall;
    logic                         req_type;
    logic [tsa_pkg::TILE_W-1:0]   tile_id;
    logic [tsa_pkg::SLOT_W-1:0]   slot_id;
    logic                         rsp_valid;
    logic                         rsp_stall;
    logic [tsa_pkg::SLOT_W-1:0]   slot;
    logic [tsa_pkg::STATUS_W-1:0] status;
    logic                         upload_needed;

    // allocator model state
    logic                          map_valid   [TILE_IDS];
    logic [tsa_pkg::SLOT_W-1:0]    map_slot    [TILE_IDS];
    logic                          owner_valid [SLOTS];
    logic [tsa_pkg::TILE_W-1:0]    owner_tile  [SLOTS];
    logic [tsa_pkg::COUNT_W-1:0]   ref_cnt     [SLOTS];
    logic [tsa_pkg::SLOT_W-1:0]    free_head;
    int                            live_slots = 0;

    rsp_t                rsp_due [$];
    word_t               dir_words [$];
    logic                dir_known [$];
    rsp_t                dir_rsp [$];

    phase_t              phase = PH_TABLE;
    word_t               cur_word;
    logic                cur_known;
    rsp_t                cur_typed;
    rsp_t                predicted;
    rsp_t                want;
    logic                src_fire;
    logic                src_drive;
    logic                have_word;
    logic                src_done = 1'b0;
    logic                quiet = 1'b0;
    logic                pressure_done = 1'b0;
    logic                next_stall;
    int                  useful = 0;
    int                  full_seen = 0;
    int                  drawn = 0;
    int                  gap_left = 0;
    int                  hold_left = 0;
    int                  results_seen = 0;
    int                  errors = 0;

    refcounted_tile_slot_allocator #(
        .TILE_IDS (TILE_IDS),
        .SLOTS    (SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .tile_id       (tile_id),
        .slot_id       (slot_id),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .slot          (slot),
        .status        (status),
        .upload_needed (upload_needed)
    );

    always #2 clk = ~clk;

    task automatic slot_map_step(input word_t w, output rsp_t r);
        logic [tsa_pkg::SLOT_W-1:0] s;
        r.slot   = '0;
        r.status = tsa_pkg::ST_IGNORED;
        r.upload = 1'b0;
        if (w.typ == REQ_ACQUIRE)
        begin
            if (w.tile != '0 && int'(w.tile) < TILE_IDS)
            begin
                if (map_valid[w.tile])
                begin
                    s = map_slot[w.tile];
                    if (ref_cnt[s] != tsa_pkg::COUNT_MAX)
                        ref_cnt[s] = ref_cnt[s] + tsa_pkg::COUNT_ONE;
                    r.slot   = s;
                    r.status = tsa_pkg::ST_HIT;
                end
                else if (free_head == '0)
                begin
                    r.status = tsa_pkg::ST_FULL;
                end
                else
                begin
                    s = free_head;
                    free_head = (ref_cnt[s] >= tsa_pkg::COUNT_W'(SLOTS)) ? '0
                                : ref_cnt[s][tsa_pkg::SLOT_W-1:0];
                    map_valid[w.tile] = 1'b1;
                    map_slot[w.tile]  = s;
                    owner_valid[s]    = 1'b1;
                    owner_tile[s]     = w.tile;
                    ref_cnt[s]        = tsa_pkg::COUNT_ONE;
                    live_slots++;
                    r.slot   = s;
                    r.status = tsa_pkg::ST_NEW;
                    r.upload = 1'b1;
                end
            end
        end
        else if (w.sid != '0 && int'(w.sid) < SLOTS && owner_valid[w.sid])
        begin
            s = w.sid;
            if (ref_cnt[s] <= tsa_pkg::COUNT_ONE)
            begin
                ref_cnt[s]    = tsa_pkg::COUNT_W'(free_head);
                free_head     = s;
                map_valid[owner_tile[s]] = 1'b0;
                owner_valid[s] = 1'b0;
                owner_tile[s]  = '0;
                live_slots--;
                r.status = tsa_pkg::ST_NEW;
            end
            else
            begin
                ref_cnt[s] = ref_cnt[s] - tsa_pkg::COUNT_ONE;
                r.status   = tsa_pkg::ST_HIT;
            end
        end
    endtask

    function automatic logic [tsa_pkg::SLOT_W-1:0] pick_live_slot();
        int base;
        int s;
        base = $urandom_range(0, SLOTS - 2);
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            s = 1 + (base + i) % (SLOTS - 1);
            if (owner_valid[s])
                return tsa_pkg::SLOT_W'(s);
        end
        return '0;
    endfunction

    function automatic logic [tsa_pkg::TILE_W-1:0] pick_free_tile();
        int base;
        int t;
        base = $urandom_range(0, TILE_IDS - 2);
        for (int i = 0; i < TILE_IDS - 1; i++)
        begin
            t = 1 + (base + i) % (TILE_IDS - 1);
            if (!map_valid[t])
                return tsa_pkg::TILE_W'(t);
        end
        return '0;
    endfunction

    function automatic logic [tsa_pkg::TILE_W-1:0] hot_tile();
        if ($urandom_range(0, 1) == 0)
            return tsa_pkg::TILE_W'($urandom_range(1, 24));
        return tsa_pkg::TILE_W'($urandom_range(TILE_IDS - 24, TILE_IDS - 1));
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input logic typ, input logic [tsa_pkg::TILE_W-1:0] tile,
                           input logic [tsa_pkg::SLOT_W-1:0] sid, input logic known,
                           input logic [tsa_pkg::SLOT_W-1:0] e_slot,
                           input logic [tsa_pkg::STATUS_W-1:0] e_status,
                           input logic e_up);
        word_t w;
        rsp_t  e;
        w.typ    = typ;
        w.tile   = tile;
        w.sid    = sid;
        e.slot   = e_slot;
        e.status = e_status;
        e.upload = e_up;
        dir_words.push_back(w);
        dir_known.push_back(known);
        dir_rsp.push_back(e);
    endtask

    task automatic draw_word(output logic ok);
        int r;
        ok        = 1'b1;
        cur_known = 1'b0;
        cur_typed = '0;
        if (phase == PH_TABLE && dir_words.size() == 0)
        begin
            phase  = PH_MIX_A;
            useful = 0;
        end
        if (phase == PH_MIX_A && useful >= MIX_WORDS)
        begin
            phase     = PH_FILL;
            full_seen = 0;
        end
        if (phase == PH_FILL && full_seen >= FULL_TRIES)
        begin
            phase  = PH_MIX_B;
            useful = 0;
        end
        if (phase == PH_MIX_B && useful >= MIX_WORDS)
            phase = PH_DONE;

        drawn++;
        if (drawn % 100 == 0)
            quiet = ($urandom_range(0, 2) == 0);

        cur_word.tile = tsa_pkg::TILE_W'($urandom_range(0, TILE_IDS - 1));
        cur_word.sid  = tsa_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
        r = $urandom_range(0, 99);
        case (phase)
            PH_TABLE:
            begin
                cur_word  = dir_words.pop_front();
                cur_known = dir_known.pop_front();
                cur_typed = dir_rsp.pop_front();
            end
            PH_MIX_A, PH_MIX_B:
            begin
                if (r < 30)
                begin
                    cur_word.typ  = REQ_ACQUIRE;
                    cur_word.tile = hot_tile();
                end
                else if (r < 45)
                begin
                    cur_word.typ = REQ_ACQUIRE;
                end
                else if (r < 85 && live_slots > 0)
                begin
                    cur_word.typ = REQ_RELEASE;
                    cur_word.sid = pick_live_slot();
                end
                else if (r < 85)
                begin
                    cur_word.typ  = REQ_ACQUIRE;
                    cur_word.tile = hot_tile();
                end
                else
                begin
                    cur_word.typ = REQ_RELEASE;
                end
            end
            PH_FILL:
            begin
                cur_word.typ = REQ_ACQUIRE;
                if (r < 80 || live_slots == 0)
                    cur_word.tile = pick_free_tile();
                else
                    cur_word.tile = owner_tile[pick_live_slot()];
            end
            default:
                ok = 1'b0;
        endcase
    endtask

    task automatic flag_error(input string what, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
        errors++;
    endtask

    // request side: predict on accept, then hold, idle or advance
    always @(posedge clk)
    begin
        src_fire  = req_valid && !req_stall;
        src_drive = req_valid && !src_fire;
        if (src_fire)
        begin
            slot_map_step(cur_word, predicted);
            rsp_due.push_back(cur_known ? cur_typed : predicted);
            if (predicted.status != tsa_pkg::ST_IGNORED)
                useful++;
            if (predicted.status == tsa_pkg::ST_FULL)
                full_seen++;
            gap_left = pick_gap();
        end
        if (rst_n && !src_drive && !src_done)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else
            begin
                draw_word(have_word);
                if (have_word)
                begin
                    src_drive = 1'b1;
                    req_type <= cur_word.typ;
                    tile_id  <= cur_word.tile;
                    slot_id  <= cur_word.sid;
                end
                else
                begin
                    src_done = 1'b1;
                end
            end
        end
        req_valid <= src_drive;
    end

    // result side: check, then pick the next stall
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (rsp_due.size() == 0)
            begin
                flag_error("unexpected word, slot", 32'hFFFF_FFFF, 32'(slot));
            end
            else
            begin
                want = rsp_due.pop_front();
                if (slot !== want.slot)
                    flag_error("slot", 32'(want.slot), 32'(slot));
                if (status !== want.status)
                    flag_error("status", 32'(want.status), 32'(status));
                if (upload_needed !== want.upload)
                    flag_error("upload_needed", 32'(want.upload), 32'(upload_needed));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            next_stall = 1'b1;
        end
        else if (!pressure_done && results_seen >= PRESSURE_AT)
        begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_LEN - 1;
            next_stall    = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 15)
        begin
            hold_left  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(7, 39);
            next_stall = 1'b1;
        end
        else
        begin
            next_stall = 1'b0;
        end
        rsp_stall <= next_stall;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_type  = REQ_ACQUIRE;
        tile_id   = '0;
        slot_id   = '0;
        rsp_stall = 1'b0;

        for (int i = 0; i < TILE_IDS; i++)
        begin
            map_valid[i] = 1'b0;
            map_slot[i]  = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            owner_valid[i] = 1'b0;
            owner_tile[i]  = '0;
            ref_cnt[i]     = (i == SLOTS - 1) ? '0 : tsa_pkg::COUNT_W'(i + 1);
        end
        free_head = tsa_pkg::SLOT_W'(1);

        add_row(REQ_ACQUIRE, 10'd0,   9'h1FF, 1'b1, 9'd0, tsa_pkg::ST_IGNORED, 1'b0);
        add_row(REQ_RELEASE, 10'h3FF, 9'd0,   1'b1, 9'd0, tsa_pkg::ST_IGNORED, 1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'h1FF, 1'b1, 9'd0, tsa_pkg::ST_IGNORED, 1'b0);
        add_row(REQ_RELEASE, 10'd5,   9'd1,   1'b1, 9'd0, tsa_pkg::ST_IGNORED, 1'b0);
        add_row(REQ_ACQUIRE, 10'h3FF, 9'h1FF, 1'b1, 9'd1, tsa_pkg::ST_NEW,     1'b1);
        add_row(REQ_ACQUIRE, 10'd1,   9'd0,   1'b1, 9'd2, tsa_pkg::ST_NEW,     1'b1);
        add_row(REQ_ACQUIRE, 10'h3FF, 9'd0,   1'b1, 9'd1, tsa_pkg::ST_HIT,     1'b0);
        add_row(REQ_ACQUIRE, 10'd1,   9'h1FF, 1'b1, 9'd2, tsa_pkg::ST_HIT,     1'b0);
        add_row(REQ_RELEASE, 10'h3FF, 9'd1,   1'b1, 9'd0, tsa_pkg::ST_HIT,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd1,   1'b1, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd1,   1'b1, 9'd0, tsa_pkg::ST_IGNORED, 1'b0);
        add_row(REQ_ACQUIRE, 10'h3FF, 9'd0,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_ACQUIRE, 10'd512, 9'd0,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd2,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd2,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_ACQUIRE, 10'h2AA, 9'h155, 1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_ACQUIRE, 10'h155, 9'h0AA, 1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_ACQUIRE, 10'd512, 9'd0,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'h3FF, 9'h1FF, 1'b1, 9'd0, tsa_pkg::ST_IGNORED, 1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd3,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd3,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd1,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd2,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);
        add_row(REQ_RELEASE, 10'd0,   9'd4,   1'b0, 9'd0, tsa_pkg::ST_NEW,     1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (!src_done || rsp_due.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/tsa_pkg.sv
sv/tsa_ram.sv
sv/tsa_sequencer.sv
sv/tsa_datapath.sv
sv/refcounted_tile_slot_allocator.sv
bench/tb_refcounted_tile_slot_allocator.sv
